// ----- sv/adjacent_token_pair_counter_core_assert.svh -----
// Assertion macros for the pair counter core.
// Clocked on clk; ATPC_ASSERT is disabled while arst_n is low, ATPC_ASSERT_ANY is not; empty for synthesis.
`ifndef ADJACENT_TOKEN_PAIR_COUNTER_CORE_ASSERT_SVH
`define ADJACENT_TOKEN_PAIR_COUNTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ATPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("pair counter assertion failed");
`define ATPC_ASSERT_ANY(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("pair counter assertion failed");
`else
`define ATPC_ASSERT(lbl, prop)
`define ATPC_ASSERT_ANY(lbl, prop)
`endif
`endif

// ----- sv/atpc_pkg.sv -----
// Shared types and defaults for the adjacent token pair counter.
// No dependencies.
package atpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int TOKEN_BITS_DEF    = 16;
	localparam int COUNT_BITS_DEF    = 32;
	localparam int CMD_BITS          = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CONT  = 2'd0,
		CMD_START = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// control part of a packet moving along the chain
	// flag: pair already counted, or query has seen a used cell
	typedef struct packed {
		logic vld;
		logic query;
		logic flag;
	} pkt_ctl_t;

endpackage

// ----- sv/adjacent_token_pair_counter_core.sv -----
// Top level of the adjacent token pair counter: front end, cell chain, result register.
// Depends on atpc_pkg, atpc_cell and adjacent_token_pair_counter_core_assert.svh.
//
// Usage: each transfer on s_axis carries one command in s_axis_tuser (continue the
// sequence, start a new sequence, or query) and one token in s_axis_tdata. A continue
// forms the pair (previous token, this token) and sends it into a chain of
// TABLE_ENTRIES cells, one table entry per cell. The pair moves one cell per cycle
// until it matches an entry (count bumps, saturating) or claims the first free one;
// a pair leaving the end unclaimed sets the sticky dropped flag.
// A query walks the same chain and picks the largest count, earliest entry on a tie,
// then lands in the m_axis result register. Only queries produce a result.
// Throughput: one transfer per cycle unless m_axis stalls; all packets advance in step.
// A query's result passes through every cell stage and then the result register before
// it shows on m_axis.
// Reset empties every cell at once through its occupancy flag and clears the flag and
// predecessor; the block accepts transfers in the first cycle after reset.
// When m_axis is stalled with a result held, the whole chain freezes and s_axis_tready
// drops until the result is taken.
`include "adjacent_token_pair_counter_core_assert.svh"

module adjacent_token_pair_counter_core
	import atpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int TOKEN_BITS    = TOKEN_BITS_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF,
	localparam int IN_W  = ((TOKEN_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * TOKEN_BITS + COUNT_BITS + 2 + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,  // token
	input  logic [CMD_BITS-1:0] s_axis_tuser,  // cmd
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// top_first, top_second, top_count, found, pairs_dropped
	output logic [OUT_W-1:0]    m_axis_tdata
);

	localparam int KEY_BITS = 2 * TOKEN_BITS;

	logic                  adv;
	logic                  acc;
	logic [TOKEN_BITS-1:0] tok;
	logic [TOKEN_BITS-1:0] prev_token_q;
	logic                  prev_valid_q;
	logic                  dropped_q;

	pkt_ctl_t              inj_ctl;
	logic [KEY_BITS-1:0]   inj_key;

	pkt_ctl_t              ctl   [0:TABLE_ENTRIES];
	logic [KEY_BITS-1:0]   key   [0:TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cnt   [0:TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] used;

	logic                  out_valid_q;
	logic [KEY_BITS-1:0]   out_key_q;
	logic [COUNT_BITS-1:0] out_cnt_q;
	logic                  out_found_q;
	logic                  out_dropped_q;

	// chain moves only when the result register is free or being emptied
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign tok           = s_axis_tdata[TOKEN_BITS-1:0];

	always_comb begin
		inj_ctl = '0;
		inj_key = {prev_token_q, tok};
		if (acc) begin
			unique case (s_axis_tuser)
				CMD_CONT: begin
					inj_ctl.vld = prev_valid_q;
				end
				CMD_QUERY: begin
					inj_ctl.vld   = 1'b1;
					inj_ctl.query = 1'b1;
					inj_key       = '0;
				end
				default: begin
					inj_ctl.vld = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
		end else if (acc && (s_axis_tuser == CMD_CONT || s_axis_tuser == CMD_START)) begin
			prev_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (s_axis_tuser == CMD_CONT || s_axis_tuser == CMD_START))
			prev_token_q <= tok;
	end

	assign ctl[0] = inj_ctl;
	assign key[0] = inj_key;
	assign cnt[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		atpc_cell #(
			.TOKEN_BITS(TOKEN_BITS),
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.in_ctl (ctl[i]),
			.in_key (key[i]),
			.in_cnt (cnt[i]),
			.out_ctl(ctl[i+1]),
			.out_key(key[i+1]),
			.out_cnt(cnt[i+1]),
			.used   (used[i])
		);
	end

	// a pair leaving the chain uncounted met a full table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (ctl[TABLE_ENTRIES].vld && !ctl[TABLE_ENTRIES].query
					&& !ctl[TABLE_ENTRIES].flag)
				dropped_q <= 1'b1;
			out_valid_q <= ctl[TABLE_ENTRIES].vld && ctl[TABLE_ENTRIES].query;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl[TABLE_ENTRIES].vld && ctl[TABLE_ENTRIES].query) begin
			out_key_q     <= key[TABLE_ENTRIES];
			out_cnt_q     <= cnt[TABLE_ENTRIES];
			out_found_q   <= ctl[TABLE_ENTRIES].flag;
			out_dropped_q <= dropped_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_dropped_q, out_found_q, out_cnt_q,
		out_key_q[TOKEN_BITS-1:0], out_key_q[KEY_BITS-1:TOKEN_BITS]});

	`ATPC_ASSERT(a_dropped_sticky, dropped_q |=> dropped_q)
	`ATPC_ASSERT(a_chain_frozen_on_stall,
		(m_axis_tvalid && !m_axis_tready) |=> $stable(ctl[TABLE_ENTRIES]))
	`ATPC_ASSERT(a_used_prefix, (used & (used + TABLE_ENTRIES'(1))) == '0)
	`ATPC_ASSERT(a_empty_result_zero,
		(m_axis_tvalid && !out_found_q) |-> (out_cnt_q == '0 && out_key_q == '0))

endmodule

// ----- sv/atpc_cell.sv -----
// One table entry of the pair counter chain plus its packet stage.
// Uses atpc_pkg for the packet control struct.
module atpc_cell
	import atpc_pkg::*;
#(
	parameter int TOKEN_BITS = TOKEN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  pkt_ctl_t                in_ctl,
	input  logic [2*TOKEN_BITS-1:0] in_key,
	input  logic [COUNT_BITS-1:0]   in_cnt,
	output pkt_ctl_t                out_ctl,
	output logic [2*TOKEN_BITS-1:0] out_key,
	output logic [COUNT_BITS-1:0]   out_cnt,
	output logic                    used
);

	localparam int KEY_BITS = 2 * TOKEN_BITS;

	logic                  used_q, used_n;
	logic [KEY_BITS-1:0]   key_q, key_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n;
	pkt_ctl_t              ctl_s1, ctl_n;
	logic [KEY_BITS-1:0]   pkey_s1, pkey_n;
	logic [COUNT_BITS-1:0] pcnt_s1, pcnt_n;

	always_comb begin
		used_n = used_q;
		key_n  = key_q;
		cnt_n  = cnt_q;
		ctl_n  = in_ctl;
		pkey_n = in_key;
		pcnt_n = in_cnt;
		if (in_ctl.vld) begin
			if (in_ctl.query) begin
				// strict compare keeps the earliest entry on a tie
				if (used_q && (!in_ctl.flag || cnt_q > in_cnt)) begin
					pkey_n     = key_q;
					pcnt_n     = cnt_q;
					ctl_n.flag = 1'b1;
				end
			end else if (!in_ctl.flag) begin
				if (used_q && key_q == in_key) begin
					if (cnt_q != {COUNT_BITS{1'b1}})
						cnt_n = cnt_q + COUNT_BITS'(1);
					ctl_n.flag = 1'b1;
				end else if (!used_q) begin
					// free cells form a suffix, so this is the next free entry
					used_n     = 1'b1;
					key_n      = in_key;
					cnt_n      = COUNT_BITS'(1);
					ctl_n.flag = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			used_q <= used_n;
			ctl_s1 <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q   <= key_n;
			cnt_q   <= cnt_n;
			pkey_s1 <= pkey_n;
			pcnt_s1 <= pcnt_n;
		end
	end

	assign out_ctl = ctl_s1;
	assign out_key = pkey_s1;
	assign out_cnt = pcnt_s1;
	assign used    = used_q;

endmodule
